>>> hw/rtl/dmrc_pkg.sv
// ----------------------------------------------------------------------------
// dmrc_pkg
// Shared types, widths and the victim LFSR step for the dual-mode read cache.
// ----------------------------------------------------------------------------
`default_nettype none

package dmrc_pkg;

    localparam int ADDR_W      = 10;
    localparam int DATA_W      = 8;
    localparam int TAG_W       = 8;
    localparam int LINE_USED_W = 2;
    localparam int LFSR_W      = 8;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 8'h01;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 8'hB8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic MODE_FULLY_ASSOC = 1'b0;
    localparam logic MODE_DIRECT      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_HIT_READ,
        ST_FILL,
        ST_DONE
    } state_t;

    // Galois right-shift step
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] cur);
        logic [LFSR_W-1:0] shifted;
        shifted = cur >> 1;
        return cur[0] ? (shifted ^ LFSR_TAPS) : shifted;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dual_mode_read_cache_top.sv
// ----------------------------------------------------------------------------
// dual_mode_read_cache_top
// Read-only byte cache in front of a backing byte memory. Mode 0 is fully
// associative with LFSR replacement once all lines are valid, mode 1 is
// direct mapped. A miss refills the whole line from backing memory.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | beat contents
//  --------+-----------+---------------------+---------------------------------
//  in      | sink      | in_valid / in_stall | opcode, address, write_data
//  out     | source    | out_valid/out_stall | read_data, hit, line_used
//  cfg     | sink      | mapping_mode_we     | mapping_mode
//
//  A load beat writes the byte to backing memory on the accepting edge
//  and the block is ready again at once. A read beat that hits passes
//  through ST_LOOKUP (tag lookup with line RAM read) and ST_HIT_READ,
//  which hands the result to the output register. A miss goes from
//  ST_LOOKUP to ST_FILL: the refill streams one byte per cycle through the
//  single read port of the backing memory, and the last byte of the line
//  ends it. The block returns to ST_IDLE once the result is loaded;
//  in_stall is high in every other state, so one read beat is in flight.
//  Reset clears valid bits, tags and mode and seeds the LFSR at once;
//  there is no clearing pass. The RAM contents are undefined until written.
//  A result waits in the output register while out_stall is high; the block
//  keeps accepting beats and only parks in ST_DONE if a second result is
//  ready before the first one has left.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_mode_read_cache_top #(
    parameter int NUM_LINES      = 4,
    parameter int WORDS_PER_LINE = 4,
    parameter int MEM_DEPTH      = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // config
    input  wire logic                                 mapping_mode_we,
    input  wire logic                                 mapping_mode,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 opcode,
    input  wire logic [dmrc_pkg::ADDR_W-1:0]          address,
    input  wire logic [dmrc_pkg::DATA_W-1:0]          write_data,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic      [dmrc_pkg::DATA_W-1:0]          read_data,
    output logic                                      hit,
    output logic      [dmrc_pkg::LINE_USED_W-1:0]     line_used
);

    import dmrc_pkg::*;

    // Line count, words per line, memory depth must be powers of two; unchecked
    localparam int OB  = $clog2(WORDS_PER_LINE);
    localparam int LB  = $clog2(NUM_LINES);
    localparam int MAW = $clog2(MEM_DEPTH);
    localparam int LAW = LB + OB;
    localparam logic [OB-1:0] WORD_LAST = OB'(WORDS_PER_LINE - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg,     state_next;
    logic                mode_reg,      mode_next;
    logic [NUM_LINES-1:0] valid_reg,    valid_next;
    logic [TAG_W-1:0]    tag_reg  [NUM_LINES];
    logic [TAG_W-1:0]    tag_next [NUM_LINES];
    logic [LFSR_W-1:0]   lfsr_reg,      lfsr_next;
    logic [ADDR_W-1:0]   addr_reg,      addr_next;
    logic [LB-1:0]       line_reg,      line_next;
    logic                hit_reg,       hit_next;
    logic [OB-1:0]       w_reg,         w_next;
    logic [DATA_W-1:0]   cap_data_reg,  cap_data_next;
    logic [DATA_W-1:0]   res_data_reg,  res_data_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg,  out_data_next;
    logic                out_hit_reg,   out_hit_next;
    logic [LB-1:0]       out_line_reg,  out_line_next;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic              mem_we;
    logic [MAW-1:0]    mem_waddr;
    logic [MAW-1:0]    mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic [OB-1:0]     mem_word;

    logic              line_we;
    logic [LAW-1:0]    line_waddr;
    logic [LAW-1:0]    line_raddr;
    logic [DATA_W-1:0] line_rdata;

    // loads go straight into backing memory on the accepting edge
    assign mem_we    = in_valid && !in_stall && (opcode == OP_LOAD);
    assign mem_waddr = MAW'(address);
    assign mem_raddr = MAW'({addr_reg[ADDR_W-1:OB], mem_word});

    dmrc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_backing_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (write_data),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dmrc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_LINES * WORDS_PER_LINE)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (mem_rdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // ------------------------------------------------------------------
    // Tag lookup on the latched address
    // ------------------------------------------------------------------
    logic [31:0]       block32;
    logic [31:0]       dm_tag32;
    logic [OB-1:0]     offset;
    logic [TAG_W-1:0]  fa_tag;
    logic [TAG_W-1:0]  dm_tag;
    logic [LB-1:0]     dm_line;
    logic              dm_hit;
    logic              fa_hit;
    logic [LB-1:0]     fa_line;
    logic              inv_any;
    logic [LB-1:0]     inv_line;
    logic [LFSR_W-1:0] lfsr_stepped;
    logic              use_lfsr;
    logic              look_hit;
    logic [LB-1:0]     look_line;
    logic [TAG_W-1:0]  look_tag;

    assign block32      = 32'(addr_reg) >> OB;
    assign dm_tag32     = block32 >> LB;
    assign offset       = addr_reg[OB-1:0];
    assign fa_tag       = block32[TAG_W-1:0];
    assign dm_tag       = dm_tag32[TAG_W-1:0];
    assign dm_line      = block32[LB-1:0];
    assign dm_hit       = valid_reg[dm_line] && (tag_reg[dm_line] == dm_tag);
    assign lfsr_stepped = lfsr_step(lfsr_reg);

    // lowest matching / lowest free line wins: scan high to low
    always_comb
    begin
        fa_hit   = 1'b0;
        fa_line  = '0;
        inv_any  = 1'b0;
        inv_line = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (tag_reg[i] == fa_tag))
            begin
                fa_hit  = 1'b1;
                fa_line = LB'(i);
            end
            if (!valid_reg[i])
            begin
                inv_any  = 1'b1;
                inv_line = LB'(i);
            end
        end
    end

    always_comb
    begin
        use_lfsr = 1'b0;
        if (mode_reg == MODE_DIRECT)
        begin
            look_hit  = dm_hit;
            look_line = dm_line;
            look_tag  = dm_tag;
        end
        else
        begin
            look_hit = fa_hit;
            look_tag = fa_tag;
            if (fa_hit)
            begin
                look_line = fa_line;
            end
            else if (inv_any)
            begin
                look_line = inv_line;
            end
            else
            begin
                use_lfsr  = 1'b1;
                look_line = lfsr_stepped[LB-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic              fin;
    logic [DATA_W-1:0] fin_data;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        valid_next     = valid_reg;
        tag_next       = tag_reg;
        lfsr_next      = lfsr_reg;
        addr_next      = addr_reg;
        line_next      = line_reg;
        hit_next       = hit_reg;
        w_next         = w_reg;
        cap_data_next  = cap_data_reg;
        res_data_next  = res_data_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_hit_next   = out_hit_reg;
        out_line_next  = out_line_reg;

        in_stall   = (state_reg != ST_IDLE);
        line_we    = 1'b0;
        line_waddr = {line_reg, w_reg};
        line_raddr = {look_line, offset};
        mem_word   = '0;
        fin        = 1'b0;
        fin_data   = res_data_reg;

        // taken beat leaves the output register
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (opcode == OP_READ))
                begin
                    addr_next  = address;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                line_next = look_line;
                hit_next  = look_hit;
                if (use_lfsr)
                begin
                    lfsr_next = lfsr_stepped;
                end
                if (look_hit)
                begin
                    state_next = ST_HIT_READ;
                end
                else
                begin
                    // claim the line now; word 0 read issues this cycle
                    valid_next[look_line] = 1'b1;
                    tag_next[look_line]   = look_tag;
                    w_next                = '0;
                    state_next            = ST_FILL;
                end
            end
            ST_HIT_READ:
            begin
                fin      = 1'b1;
                fin_data = line_rdata;
            end
            ST_FILL:
            begin
                // mem_rdata holds word w_reg; issue the next word
                line_we  = 1'b1;
                mem_word = w_reg + OB'(1);
                if (w_reg == offset)
                begin
                    cap_data_next = mem_rdata;
                end
                if (w_reg == WORD_LAST)
                begin
                    fin      = 1'b1;
                    fin_data = (w_reg == offset) ? mem_rdata : cap_data_reg;
                end
                else
                begin
                    w_next = w_reg + OB'(1);
                end
            end
            ST_DONE:
            begin
                fin      = 1'b1;
                fin_data = res_data_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = fin_data;
                out_hit_next   = hit_reg;
                out_line_next  = line_reg;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_data_next = fin_data;
                state_next    = ST_DONE;
            end
        end

        // mode change drops every line
        if (mapping_mode_we)
        begin
            mode_next  = mapping_mode;
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_FULLY_ASSOC;
            valid_reg     <= '0;
            lfsr_reg      <= LFSR_SEED;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            valid_reg     <= valid_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            tag_reg       <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        line_reg     <= line_next;
        hit_reg      <= hit_next;
        w_reg        <= w_next;
        cap_data_reg <= cap_data_next;
        res_data_reg <= res_data_next;
        out_data_reg <= out_data_next;
        out_hit_reg  <= out_hit_next;
        out_line_reg <= out_line_next;
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign hit       = out_hit_reg;
    assign line_used = LINE_USED_W'(out_line_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_line_valid_after_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) && !mapping_mode_we |=> valid_reg[line_reg]
    ) else $error("chosen line not valid after lookup");

    a_lfsr_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0
    ) else $error("victim LFSR reached zero");

    a_mode_write_clears: assert property (
        @(posedge clk) disable iff (!rst_n)
        mapping_mode_we |=> (valid_reg == '0)
    ) else $error("mode write left lines valid");

    a_fill_ends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) && (w_reg == WORD_LAST)
            |=> (state_reg == ST_IDLE) || (state_reg == ST_DONE)
    ) else $error("refill did not finish after last word");

    a_result_from_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_HIT_READ)
            || $past(state_reg == ST_FILL) || $past(state_reg == ST_DONE)
    ) else $error("result loaded outside a read sequence");

endmodule

`default_nettype wire

>>> hw/rtl/dmrc_ram.sv
// ----------------------------------------------------------------------------
// dmrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire
